>>> rtl/core/lfpd_pkg.sv
// Shared types and constants for the line follower PD steering core.
`default_nettype none
package lfpd_pkg;

   localparam int SENSOR_COUNT = 12;
   localparam int MODE_W       = 2;
   localparam int LEVEL_W      = 12;
   localparam int SPEED_W      = 12;
   localparam int GAIN_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int DRIVE_W      = 13;
   localparam int LERR_W       = 15;
   localparam int PREV_W       = 16;
   localparam int ERR_W        = 24;   // line error, 8 fraction bits
   localparam int QUOT_W       = 23;   // |error| <= 6 * 768000 < 2**23
   localparam int PP_W         = 41;   // gain_p * error
   localparam int PDP_W        = 42;   // gain_d * error delta
   localparam int PDS_W        = 43;
   localparam int PD_W         = 27;
   localparam int DSUM_W       = 28;

   // 3000 * 256
   localparam logic [19:0] ERR_SCALE = 20'd768000;
   // floor(135*x/100) = (x * 135 * ceil(2**27/100)) >> 27 for 12-bit x
   localparam int LIMIT_SHIFT = 27;
   localparam logic [27:0] LIMIT_MULT = 28'd181194030;
   localparam logic [SPEED_W-1:0] SPEED_KNEE = 12'd160;

   localparam logic [MODE_W-1:0] MODE_NORMAL        = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BRIDGE_LINEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BRIDGE_FLAT   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRACK_MODE   = 3'd0,
      CSR_BASE_SPEED   = 3'd1,
      CSR_GAIN_P       = 3'd2,
      CSR_GAIN_D       = 3'd3,
      CSR_WHITE_LEVEL  = 3'd4,
      CSR_GREEN_LEVEL  = 3'd5,
      CSR_STRIPE_LEVEL = 3'd6
   } csr_index_type;

   localparam logic [LEVEL_W-1:0] WHITE_RESET  = 12'd250;
   localparam logic [LEVEL_W-1:0] GREEN_RESET  = 12'd140;
   localparam logic [LEVEL_W-1:0] STRIPE_RESET = 12'd250;

   // row 3 is never selected; it repeats the normal set
   localparam logic signed [3:0] WEIGHT_TAB [4][SENSOR_COUNT] = '{
      '{4'sd3, 4'sd5, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
        -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd3},
      '{4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd5, 4'sd6,
        -4'sd6, -4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1},
      '{4'sd2, 4'sd2, 4'sd2, 4'sd2, 4'sd3, 4'sd3,
        -4'sd3, -4'sd3, -4'sd2, -4'sd2, -4'sd2, -4'sd2},
      '{4'sd3, 4'sd5, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
        -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd3}
   };

   typedef struct packed {
      logic white;
      logic green;
      logic stripe;
   } lane_flags_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_status_type;

endpackage
`default_nettype wire

>>> rtl/core/lfpd_if.sv
// Request and response channel interfaces of the steering core.
`default_nettype none
interface lfpd_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_0;
   logic [SAMPLE_BITS-1:0] sample_1;
   logic [SAMPLE_BITS-1:0] sample_2;
   logic [SAMPLE_BITS-1:0] sample_3;
   logic [SAMPLE_BITS-1:0] sample_4;
   logic [SAMPLE_BITS-1:0] sample_5;
   logic [SAMPLE_BITS-1:0] sample_6;
   logic [SAMPLE_BITS-1:0] sample_7;
   logic [SAMPLE_BITS-1:0] sample_8;
   logic [SAMPLE_BITS-1:0] sample_9;
   logic [SAMPLE_BITS-1:0] sample_10;
   logic [SAMPLE_BITS-1:0] sample_11;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   sample_5, sample_6, sample_7, sample_8, sample_9, sample_10,
                   sample_11, input ready);
   modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                 sample_5, sample_6, sample_7, sample_8, sample_9, sample_10,
                 sample_11, output ready);
endinterface

interface lfpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lfpd_pkg::DRIVE_W-1:0]        right_drive;
   logic [lfpd_pkg::DRIVE_W-1:0]        left_drive;
   logic signed [lfpd_pkg::LERR_W-1:0]  line_error;

   modport source (output valid, right_drive, left_drive, line_error, input ready);
   modport sink (input valid, right_drive, left_drive, line_error, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lfpd_lane.sv
// One sensor lane: weighted sample and threshold flags.
`default_nettype none
module lfpd_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int LANE        = 0
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [lfpd_pkg::MODE_W-1:0]   wset,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [lfpd_pkg::LEVEL_W-1:0]  white_level,
   input  logic [lfpd_pkg::LEVEL_W-1:0]  green_level,
   input  logic [lfpd_pkg::LEVEL_W-1:0]  stripe_level,
   output logic [SAMPLE_BITS-1:0]        sample_q,
   output logic signed [SAMPLE_BITS+3:0] prod,
   output lfpd_pkg::lane_flags_type      flags
);
   localparam int PROD_W = SAMPLE_BITS + 4;
   localparam int CMP_W  = (SAMPLE_BITS > lfpd_pkg::LEVEL_W) ? SAMPLE_BITS
                                                             : lfpd_pkg::LEVEL_W;

   logic signed [3:0]        wt;
   logic signed [PROD_W-1:0] wt_ext;
   logic signed [PROD_W-1:0] smp_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic [CMP_W-1:0]         smp_cmp;
   lfpd_pkg::lane_flags_type flags_in;

   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic signed [PROD_W-1:0] prod_ff;
   lfpd_pkg::lane_flags_type flags_ff;

   always_comb begin
      wt       = lfpd_pkg::WEIGHT_TAB[wset][LANE];
      wt_ext   = {{(PROD_W-4){wt[3]}}, wt};
      smp_ext  = {4'b0000, sample};
      prod_in  = wt_ext * smp_ext;
      smp_cmp  = CMP_W'(sample);
      flags_in.white  = smp_cmp > CMP_W'(white_level);
      flags_in.green  = smp_cmp < CMP_W'(green_level);
      flags_in.stripe = smp_cmp > CMP_W'(stripe_level);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample;
         prod_ff   <= prod_in;
         flags_ff  <= flags_in;
      end
   end

   assign sample_q = sample_ff;
   assign prod     = prod_ff;
   assign flags    = flags_ff;

endmodule
`default_nettype wire

>>> rtl/core/lfpd_merge.sv
// Merge stage: sums the lanes and evaluates the error guards.
`default_nettype none
module lfpd_merge #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          bridge,
   input  logic [SAMPLE_BITS-1:0]        sample_q [lfpd_pkg::SENSOR_COUNT],
   input  logic signed [SAMPLE_BITS+3:0] prod     [lfpd_pkg::SENSOR_COUNT],
   input  lfpd_pkg::lane_flags_type      flags    [lfpd_pkg::SENSOR_COUNT],
   output logic signed [SAMPLE_BITS+6:0] wsum,
   output logic [SAMPLE_BITS+3:0]        total,
   output logic                          zero
);
   localparam int WSUM_W = SAMPLE_BITS + 7;
   localparam int TOT_W  = SAMPLE_BITS + 4;

   logic signed [WSUM_W-1:0] wsum_in;
   logic [TOT_W-1:0]         total_in;
   logic                     zero_in;
   logic [3:0]               stripes;
   logic                     all_white, all_green;
   logic                     c_white, l_white, r_white, guard;

   logic signed [WSUM_W-1:0] wsum_ff;
   logic [TOT_W-1:0]         total_ff;
   logic                     zero_ff;

   always_comb begin
      wsum_in   = '0;
      total_in  = '0;
      stripes   = '0;
      all_white = 1'b1;
      all_green = 1'b1;
      for (int i = 0; i < lfpd_pkg::SENSOR_COUNT; i++) begin
         wsum_in  = wsum_in + WSUM_W'(prod[i]);
         total_in = total_in + TOT_W'(sample_q[i]);
         stripes  = stripes + {3'b000, flags[i].stripe};
      end
      // the outer two sensors stay out of the all-white / all-green tests
      for (int i = 1; i < lfpd_pkg::SENSOR_COUNT - 1; i++) begin
         all_white = all_white & flags[i].white;
         all_green = all_green & flags[i].green;
      end
      c_white = flags[5].white | flags[6].white;
      l_white = flags[0].white | flags[1].white;
      r_white = flags[10].white | flags[11].white;
      guard   = all_white | all_green | (flags[5].white & flags[6].white) |
                (c_white & l_white) | (c_white & r_white) | (stripes >= 4'd3);
      zero_in = (total_in == '0) | (!bridge & guard);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wsum_ff  <= wsum_in;
         total_ff <= total_in;
         zero_ff  <= zero_in;
      end
   end

   assign wsum  = wsum_ff;
   assign total = total_ff;
   assign zero  = zero_ff;

endmodule
`default_nettype wire

>>> rtl/core/lfpd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lfpd_div #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,
   output lfpd_pkg::div_status_type status
);
   localparam int QW    = lfpd_pkg::QUOT_W;
   localparam int CNT_W = $clog2(QW);
   localparam int HI_W  = NUM_W - QW;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [QW-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // quotient is known to fit QW bits, so the high numerator part is below den
   always_comb begin
      trial   = {rem_ff, low_ff[QW-1]};
      diff    = trial - {1'b0, den};
      fits    = !diff[DEN_W];
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QW]};
         low_in  = num[QW-1:0];
         cnt_in  = CNT_W'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in  = {low_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule
`default_nettype wire

>>> rtl/core/line_follow_pd_steering_core.sv
// One word is processed at a time; the 23-step divider by the sample sum, skipped
//   when the error is forced to zero, sets the word rate, and a new word is taken
//   while the previous result waits.
// Reset: synchronous, clears control, loads register defaults and zeroes the
//   stored previous error; no clearing pass.
`default_nettype none
module line_follow_pd_steering_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   lfpd_req_if.sink                           req_bus,
   lfpd_rsp_if.source                         rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   localparam int SC     = lfpd_pkg::SENSOR_COUNT;
   localparam int PROD_W = SAMPLE_BITS + 4;
   localparam int WSUM_W = SAMPLE_BITS + 7;
   localparam int MAG_W  = SAMPLE_BITS + 6;
   localparam int TOT_W  = SAMPLE_BITS + 4;
   localparam int NUM_W  = SAMPLE_BITS + 26;
   localparam int ERR_W  = lfpd_pkg::ERR_W;
   localparam int DRV_W  = lfpd_pkg::DRIVE_W;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MERGE    = 8'b0000_0010,
      ST_SCALE    = 8'b0000_0100,
      ST_DIV_GO   = 8'b0000_1000,
      ST_DIV_WAIT = 8'b0001_0000,
      ST_PD_MUL   = 8'b0010_0000,
      ST_PD_SUM   = 8'b0100_0000,
      ST_DRIVE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [lfpd_pkg::MODE_W-1:0]  mode_ff;
   logic [lfpd_pkg::SPEED_W-1:0] speed_ff;
   logic [lfpd_pkg::GAIN_W-1:0]  gain_p_ff;
   logic [lfpd_pkg::GAIN_W-1:0]  gain_d_ff;
   logic [lfpd_pkg::LEVEL_W-1:0] white_ff;
   logic [lfpd_pkg::LEVEL_W-1:0] green_ff;
   logic [lfpd_pkg::LEVEL_W-1:0] stripe_ff;

   logic                         bridge;
   logic [lfpd_pkg::MODE_W-1:0]  wset;
   logic                         accept;

   logic [SAMPLE_BITS-1:0]       samples  [SC];
   logic [SAMPLE_BITS-1:0]       lane_smp [SC];
   logic signed [PROD_W-1:0]     lane_prod[SC];
   lfpd_pkg::lane_flags_type     lane_flags[SC];

   logic signed [WSUM_W-1:0]     wsum;
   logic [TOT_W-1:0]             total;
   logic                         zero;

   logic signed [WSUM_W-1:0]     wsum_neg;
   logic [MAG_W-1:0]             wsum_mag;
   logic [NUM_W-1:0]             num_in;
   logic [NUM_W-1:0]             num_ff;
   logic                         neg_ff;

   lfpd_pkg::div_status_type     div_stat;
   logic [ERR_W-1:0]             quot_ext;
   logic signed [ERR_W-1:0]      err_in;
   logic signed [ERR_W-1:0]      err_ff;
   logic signed [ERR_W-1:0]      err_round;
   logic signed [lfpd_pkg::PREV_W-1:0] prev_ff, prev_in;

   logic signed [lfpd_pkg::PP_W-1:0]  gp_ext, err_pp, pp_in, pp_ff;
   logic signed [lfpd_pkg::PDP_W-1:0] gd_ext, delta, pdp_in, pdp_ff;
   logic signed [lfpd_pkg::PDS_W-1:0] pd_sum, pd_bias;
   logic signed [lfpd_pkg::PD_W-1:0]  pd_ff, pd_in;

   logic [39:0]                  lim_prod;
   logic [lfpd_pkg::SPEED_W+1:0] lim_x3;
   logic [DRV_W-1:0]             limit_in, limit_ff;

   logic signed [lfpd_pkg::DSUM_W-1:0] base_ext, pd_ext, right_sum, left_sum;
   logic [DRV_W-1:0]             right_clip, left_clip;
   logic signed [lfpd_pkg::LERR_W-1:0] shown;

   logic                         drive_load;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DRV_W-1:0]             rsp_right_ff, rsp_left_ff;
   logic signed [lfpd_pkg::LERR_W-1:0] rsp_err_ff;

   // ---------------- configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lfpd_pkg::MODE_NORMAL;
         speed_ff  <= '0;
         gain_p_ff <= '0;
         gain_d_ff <= '0;
         white_ff  <= lfpd_pkg::WHITE_RESET;
         green_ff  <= lfpd_pkg::GREEN_RESET;
         stripe_ff <= lfpd_pkg::STRIPE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lfpd_pkg::CSR_TRACK_MODE:   mode_ff   <= csr_wr_data[lfpd_pkg::MODE_W-1:0];
            lfpd_pkg::CSR_BASE_SPEED:   speed_ff  <= csr_wr_data[lfpd_pkg::SPEED_W-1:0];
            lfpd_pkg::CSR_GAIN_P:       gain_p_ff <= csr_wr_data[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::CSR_GAIN_D:       gain_d_ff <= csr_wr_data[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::CSR_WHITE_LEVEL:  white_ff  <= csr_wr_data[lfpd_pkg::LEVEL_W-1:0];
            lfpd_pkg::CSR_GREEN_LEVEL:  green_ff  <= csr_wr_data[lfpd_pkg::LEVEL_W-1:0];
            lfpd_pkg::CSR_STRIPE_LEVEL: stripe_ff <= csr_wr_data[lfpd_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   assign bridge = (mode_ff == lfpd_pkg::MODE_BRIDGE_LINEAR) ||
                   (mode_ff == lfpd_pkg::MODE_BRIDGE_FLAT);
   assign wset   = bridge ? mode_ff : lfpd_pkg::MODE_NORMAL;

   // ---------------- input and lanes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign samples[0]  = SAMPLE_BITS'(req_bus.sample_0);
   assign samples[1]  = SAMPLE_BITS'(req_bus.sample_1);
   assign samples[2]  = SAMPLE_BITS'(req_bus.sample_2);
   assign samples[3]  = SAMPLE_BITS'(req_bus.sample_3);
   assign samples[4]  = SAMPLE_BITS'(req_bus.sample_4);
   assign samples[5]  = SAMPLE_BITS'(req_bus.sample_5);
   assign samples[6]  = SAMPLE_BITS'(req_bus.sample_6);
   assign samples[7]  = SAMPLE_BITS'(req_bus.sample_7);
   assign samples[8]  = SAMPLE_BITS'(req_bus.sample_8);
   assign samples[9]  = SAMPLE_BITS'(req_bus.sample_9);
   assign samples[10] = SAMPLE_BITS'(req_bus.sample_10);
   assign samples[11] = SAMPLE_BITS'(req_bus.sample_11);

   for (genvar g = 0; g < SC; g++) begin : g_lane
      lfpd_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .LANE        (g)
      ) u_lane (
         .clock        (clock),
         .load         (accept),
         .wset         (wset),
         .sample       (samples[g]),
         .white_level  (white_ff),
         .green_level  (green_ff),
         .stripe_level (stripe_ff),
         .sample_q     (lane_smp[g]),
         .prod         (lane_prod[g]),
         .flags        (lane_flags[g])
      );
   end

   lfpd_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock    (clock),
      .load     (state_ff == ST_MERGE),
      .bridge   (bridge),
      .sample_q (lane_smp),
      .prod     (lane_prod),
      .flags    (lane_flags),
      .wsum     (wsum),
      .total    (total),
      .zero     (zero)
   );

   // ---------------- numerator scale and divide
   always_comb begin
      wsum_neg = -wsum;
      wsum_mag = wsum[WSUM_W-1] ? wsum_neg[MAG_W-1:0] : wsum[MAG_W-1:0];
      num_in   = {{20{1'b0}}, wsum_mag} * {{MAG_W{1'b0}}, lfpd_pkg::ERR_SCALE};
   end

   lfpd_div #(
      .NUM_W (NUM_W),
      .DEN_W (TOT_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_DIV_GO),
      .num    (num_ff),
      .den    (total),
      .status (div_stat)
   );

   always_comb begin
      quot_ext = {1'b0, div_stat.quotient};
      err_in   = neg_ff ? -$signed(quot_ext) : $signed(quot_ext);
   end

   // ---------------- PD term and wheel limit
   always_comb begin
      gp_ext   = {{(lfpd_pkg::PP_W-lfpd_pkg::GAIN_W){1'b0}}, gain_p_ff};
      err_pp   = lfpd_pkg::PP_W'(err_ff);
      pp_in    = gp_ext * err_pp;
      gd_ext   = {{(lfpd_pkg::PDP_W-lfpd_pkg::GAIN_W){1'b0}}, gain_d_ff};
      delta    = lfpd_pkg::PDP_W'(err_ff) -
                 $signed({(lfpd_pkg::PDP_W-8)'(prev_ff), 8'h00});
      pdp_in   = gd_ext * delta;
      lim_prod = {28'd0, speed_ff} * {12'd0, lfpd_pkg::LIMIT_MULT};
      lim_x3   = {1'b0, speed_ff, 1'b0} + {2'b00, speed_ff};
      if (!bridge && speed_ff >= lfpd_pkg::SPEED_KNEE)
         limit_in = lim_prod[lfpd_pkg::LIMIT_SHIFT +: DRV_W];
      else
         limit_in = lim_x3[DRV_W:1];
   end

   // divisions truncate toward zero: bias negatives before the shift
   always_comb begin
      pd_sum    = lfpd_pkg::PDS_W'(pp_ff) + lfpd_pkg::PDS_W'(pdp_ff);
      pd_bias   = pd_sum + (pd_sum[lfpd_pkg::PDS_W-1] ? lfpd_pkg::PDS_W'(16'hFFFF)
                                                       : lfpd_pkg::PDS_W'(0));
      pd_in     = pd_bias[lfpd_pkg::PDS_W-1:16];
      err_round = err_ff + (err_ff[ERR_W-1] ? ERR_W'(8'hFF) : ERR_W'(0));
      prev_in   = err_round[8 +: lfpd_pkg::PREV_W];
   end

   // ---------------- wheel drive
   always_comb begin
      base_ext  = {{(lfpd_pkg::DSUM_W-lfpd_pkg::SPEED_W){1'b0}}, speed_ff};
      pd_ext    = lfpd_pkg::DSUM_W'(pd_ff);
      right_sum = bridge ? base_ext + pd_ext : base_ext - pd_ext;
      left_sum  = bridge ? base_ext - pd_ext : base_ext + pd_ext;
      if (right_sum < 0)
         right_clip = '0;
      else if (right_sum > $signed({{(lfpd_pkg::DSUM_W-DRV_W){1'b0}}, limit_ff}))
         right_clip = limit_ff;
      else
         right_clip = right_sum[DRV_W-1:0];
      if (left_sum < 0)
         left_clip = '0;
      else if (left_sum > $signed({{(lfpd_pkg::DSUM_W-DRV_W){1'b0}}, limit_ff}))
         left_clip = limit_ff;
      else
         left_clip = left_sum[DRV_W-1:0];
      if (prev_ff > 16'sd16383)
         shown = 15'sd16383;
      else if (prev_ff < -16'sd16384)
         shown = -15'sd16384;
      else
         shown = prev_ff[lfpd_pkg::LERR_W-1:0];
   end

   assign drive_load = (state_ff == ST_DRIVE) && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_MERGE;
         ST_MERGE:    state_in = ST_SCALE;
         ST_SCALE:    state_in = zero ? ST_PD_MUL : ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_stat.done) state_in = ST_PD_MUL;
         ST_PD_MUL:   state_in = ST_PD_SUM;
         ST_PD_SUM:   state_in = ST_DRIVE;
         ST_DRIVE:    if (drive_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready)
         rsp_valid_in = 1'b0;
      if (drive_load)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_PD_SUM)
            prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         num_ff <= num_in;
         neg_ff <= wsum[WSUM_W-1];
         if (zero)
            err_ff <= '0;
      end
      if (state_ff == ST_DIV_WAIT && div_stat.done)
         err_ff <= err_in;
      if (state_ff == ST_PD_MUL) begin
         pp_ff    <= pp_in;
         pdp_ff   <= pdp_in;
         limit_ff <= limit_in;
      end
      if (state_ff == ST_PD_SUM)
         pd_ff <= pd_in;
      if (drive_load) begin
         rsp_right_ff <= right_clip;
         rsp_left_ff  <= left_clip;
         rsp_err_ff   <= shown;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.right_drive = rsp_right_ff;
   assign rsp_bus.left_drive  = rsp_left_ff;
   assign rsp_bus.line_error  = rsp_err_ff;

   // ---------------- checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_MERGE))
      else $error("accepted word did not enter the merge step");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside its wait step");

   a_drive_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_right_ff <= limit_ff && rsp_left_ff <= limit_ff))
      else $error("wheel drive above its limit");

endmodule
`default_nettype wire

>>> tb/sv/line_follow_pd_steering_core_tb.sv
// Self-checking testbench for the line follower PD steering core.
module line_follow_pd_steering_core_tb;

   localparam int SAMPLE_BITS = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [lfpd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   // weight rows: normal, bridge linear, bridge flat
   localparam int WEIGHTS [3][lfpd_pkg::SENSOR_COUNT] = '{
      '{3, 5, 4, 3, 2, 1, -1, -2, -3, -4, -5, -3},
      '{1, 2, 3, 4, 5, 6, -6, -5, -4, -3, -2, -1},
      '{2, 2, 2, 2, 3, 3, -3, -3, -2, -2, -2, -2}
   };

   typedef logic [SAMPLE_BITS-1:0] sample_set_t [lfpd_pkg::SENSOR_COUNT];

   typedef struct {
      logic [lfpd_pkg::DRIVE_W-1:0]        right;
      logic [lfpd_pkg::DRIVE_W-1:0]        left;
      logic signed [lfpd_pkg::LERR_W-1:0]  err;
   } drive_t;

   class steer_ledger;
      logic [lfpd_pkg::MODE_W-1:0]  mode;
      logic [lfpd_pkg::SPEED_W-1:0] speed;
      logic [lfpd_pkg::GAIN_W-1:0]  kp;
      logic [lfpd_pkg::GAIN_W-1:0]  kd;
      logic [lfpd_pkg::LEVEL_W-1:0] white;
      logic [lfpd_pkg::LEVEL_W-1:0] green;
      logic [lfpd_pkg::LEVEL_W-1:0] stripe;
      longint             last_err;
      drive_t             pending_drives[$];
      int                 faults;
      int                 checked;

      function new();
         mode = lfpd_pkg::MODE_NORMAL;
         speed = '0;
         kp = '0;
         kd = '0;
         white = 12'd250;
         green = 12'd140;
         stripe = 12'd250;
         last_err = 0;
         faults = 0;
         checked = 0;
      endfunction

      function void set_reg(lfpd_pkg::csr_index_type idx,
                            logic [lfpd_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            lfpd_pkg::CSR_TRACK_MODE:   mode = v[lfpd_pkg::MODE_W-1:0];
            lfpd_pkg::CSR_BASE_SPEED:   speed = v[lfpd_pkg::SPEED_W-1:0];
            lfpd_pkg::CSR_GAIN_P:       kp = v[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::CSR_GAIN_D:       kd = v[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::CSR_WHITE_LEVEL:  white = v[lfpd_pkg::LEVEL_W-1:0];
            lfpd_pkg::CSR_GREEN_LEVEL:  green = v[lfpd_pkg::LEVEL_W-1:0];
            lfpd_pkg::CSR_STRIPE_LEVEL: stripe = v[lfpd_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function drive_t steer_for(sample_set_t s);
         drive_t r;
         longint total, wsum, sv, err, pd, lkp, lkd, lspd, right, left, limit, shown;
         int     stripes, row;
         bit     bridge, zero, all_white, all_green, cw, lw, rw;
         bridge = (mode == lfpd_pkg::MODE_BRIDGE_LINEAR) ||
                  (mode == lfpd_pkg::MODE_BRIDGE_FLAT);
         row = bridge ? int'(mode) : 0;
         total = 0;
         wsum = 0;
         stripes = 0;
         for (int i = 0; i < lfpd_pkg::SENSOR_COUNT; i++) begin
            sv = s[i];
            total += sv;
            wsum += WEIGHTS[row][i] * sv;
            if (s[i] > stripe) stripes++;
         end
         zero = 0;
         if (!bridge) begin
            all_white = 1;
            all_green = 1;
            for (int i = 1; i <= 10; i++) begin
               if (!(s[i] > white)) all_white = 0;
               if (!(s[i] < green)) all_green = 0;
            end
            cw = (s[5] > white) || (s[6] > white);
            lw = (s[0] > white) || (s[1] > white);
            rw = (s[10] > white) || (s[11] > white);
            zero = all_white || all_green || ((s[5] > white) && (s[6] > white)) ||
                   (cw && lw) || (cw && rw) || (stripes >= 3);
         end
         err = 0;
         if (!zero && total > 0) err = (wsum * 768000) / total;
         lkp = kp;
         lkd = kd;
         pd = (lkp * err + lkd * (err - last_err * 256)) / 65536;
         last_err = err / 256;
         lspd = speed;
         if (bridge) begin
            right = lspd + pd;
            left = lspd - pd;
         end else begin
            right = lspd - pd;
            left = lspd + pd;
         end
         if (!bridge && speed >= 160) limit = (lspd * 135) / 100;
         else limit = (lspd * 3) / 2;
         if (right < 0) right = 0;
         if (right > limit) right = limit;
         if (left < 0) left = 0;
         if (left > limit) left = limit;
         shown = last_err;
         if (shown > 16383) shown = 16383;
         if (shown < -16384) shown = -16384;
         r.right = right[lfpd_pkg::DRIVE_W-1:0];
         r.left = left[lfpd_pkg::DRIVE_W-1:0];
         r.err = shown[lfpd_pkg::LERR_W-1:0];
         return r;
      endfunction

      function void note_frame(sample_set_t s);
         pending_drives.push_back(steer_for(s));
      endfunction

      function void check_drive(drive_t got);
         drive_t want;
         checked++;
         if (pending_drives.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("drive word %0d arrived with nothing outstanding: right %0d left %0d err %0d",
                        checked, got.right, got.left, got.err);
            return;
         end
         want = pending_drives.pop_front();
         if (got.right !== want.right || got.left !== want.left || got.err !== want.err) begin
            faults++;
            if (faults <= 10)
               $display("drive word %0d: exp right %0d left %0d err %0d, got right %0d left %0d err %0d",
                        checked, want.right, want.left, want.err, got.right, got.left, got.err);
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_wr_en;
   logic [lfpd_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_wr_data;
   bit                                calm;
   int                                cycles = 0;
   int                                frames_sent = 0;
   int                                settings_loaded = 0;
   steer_ledger                       ledger;

   lfpd_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   lfpd_rsp_if rsp_bus ();

   line_follow_pd_steering_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // input word monitor
   always @(posedge clock) begin : watch_req
      sample_set_t seen;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen[0] = req_bus.sample_0;
         seen[1] = req_bus.sample_1;
         seen[2] = req_bus.sample_2;
         seen[3] = req_bus.sample_3;
         seen[4] = req_bus.sample_4;
         seen[5] = req_bus.sample_5;
         seen[6] = req_bus.sample_6;
         seen[7] = req_bus.sample_7;
         seen[8] = req_bus.sample_8;
         seen[9] = req_bus.sample_9;
         seen[10] = req_bus.sample_10;
         seen[11] = req_bus.sample_11;
         ledger.note_frame(seen);
         frames_sent++;
      end
   end

   // result word monitor
   always @(posedge clock) begin : watch_rsp
      drive_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.right = rsp_bus.right_drive;
         got.left = rsp_bus.left_drive;
         got.err = rsp_bus.line_error;
         ledger.check_drive(got);
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : int'($urandom_range(0, 3));
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_frame(input sample_set_t f);
      int gap;
      gap = calm ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample_0 <= f[0];
      req_bus.sample_1 <= f[1];
      req_bus.sample_2 <= f[2];
      req_bus.sample_3 <= f[3];
      req_bus.sample_4 <= f[4];
      req_bus.sample_5 <= f[5];
      req_bus.sample_6 <= f[6];
      req_bus.sample_7 <= f[7];
      req_bus.sample_8 <= f[8];
      req_bus.sample_9 <= f[9];
      req_bus.sample_10 <= f[10];
      req_bus.sample_11 <= f[11];
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold the sender off until every outstanding drive word is back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input lfpd_pkg::csr_index_type idx,
                            input logic [lfpd_pkg::CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= v;
      @(posedge clock);
      ledger.set_reg(idx, v);
   endtask

   task automatic setup(input logic [lfpd_pkg::MODE_W-1:0] m,
                        input logic [lfpd_pkg::SPEED_W-1:0] spd,
                        input logic [lfpd_pkg::GAIN_W-1:0] p,
                        input logic [lfpd_pkg::GAIN_W-1:0] d,
                        input logic [lfpd_pkg::LEVEL_W-1:0] w,
                        input logic [lfpd_pkg::LEVEL_W-1:0] g,
                        input logic [lfpd_pkg::LEVEL_W-1:0] st);
      write_reg(lfpd_pkg::CSR_TRACK_MODE, lfpd_pkg::CSR_DATA_W'(m));
      write_reg(lfpd_pkg::CSR_BASE_SPEED, lfpd_pkg::CSR_DATA_W'(spd));
      write_reg(lfpd_pkg::CSR_GAIN_P, p);
      write_reg(lfpd_pkg::CSR_GAIN_D, d);
      write_reg(lfpd_pkg::CSR_WHITE_LEVEL, lfpd_pkg::CSR_DATA_W'(w));
      write_reg(lfpd_pkg::CSR_GREEN_LEVEL, lfpd_pkg::CSR_DATA_W'(g));
      write_reg(lfpd_pkg::CSR_STRIPE_LEVEL, lfpd_pkg::CSR_DATA_W'(st));
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_setup();
      logic [lfpd_pkg::SPEED_W-1:0] spd;
      logic [lfpd_pkg::LEVEL_W-1:0] w, g, st;
      if ($urandom_range(0, 3) == 0) spd = lfpd_pkg::SPEED_W'($urandom_range(0, 4095));
      else spd = lfpd_pkg::SPEED_W'($urandom_range(100, 400));
      if ($urandom_range(0, 4) == 0) begin
         w = lfpd_pkg::LEVEL_W'($urandom_range(0, 4095));
         g = lfpd_pkg::LEVEL_W'($urandom_range(0, 4095));
         st = lfpd_pkg::LEVEL_W'($urandom_range(0, 4095));
      end else begin
         w = lfpd_pkg::LEVEL_W'($urandom_range(200, 400));
         g = lfpd_pkg::LEVEL_W'($urandom_range(60, 200));
         st = lfpd_pkg::LEVEL_W'($urandom_range(200, 400));
      end
      setup(lfpd_pkg::MODE_W'($urandom_range(0, 3)), spd,
            lfpd_pkg::GAIN_W'($urandom_range(0, 65535)),
            lfpd_pkg::GAIN_W'($urandom_range(0, 65535)), w, g, st);
   endtask

   function automatic sample_set_t flat(input logic [SAMPLE_BITS-1:0] v);
      sample_set_t f;
      foreach (f[i]) f[i] = v;
      return f;
   endfunction

   function automatic sample_set_t spot(input int idx, input logic [SAMPLE_BITS-1:0] v,
                                        input logic [SAMPLE_BITS-1:0] bg);
      sample_set_t f;
      f = flat(bg);
      f[idx] = v;
      return f;
   endfunction

   // background of 0 to 220 with one bright line, the common case
   function automatic sample_set_t line_scene();
      sample_set_t f;
      int base, pos, width;
      base = int'($urandom_range(0, 180));
      foreach (f[i]) f[i] = SAMPLE_BITS'(base + int'($urandom_range(0, 40)));
      pos = int'($urandom_range(0, lfpd_pkg::SENSOR_COUNT - 1));
      width = int'($urandom_range(1, 3));
      for (int i = pos; i < pos + width && i < lfpd_pkg::SENSOR_COUNT; i++)
         f[i] = SAMPLE_BITS'($urandom_range(300, 4095));
      return f;
   endfunction

   function automatic sample_set_t random_scene();
      sample_set_t f;
      int kind;
      logic [lfpd_pkg::LEVEL_W-1:0] wl, gl;
      wl = ledger.white;
      gl = ledger.green;
      kind = int'($urandom_range(0, 9));
      if (kind < 5) begin
         f = line_scene();
      end else if (kind == 5) begin
         f = line_scene();
         f[$urandom_range(0, lfpd_pkg::SENSOR_COUNT - 1)] =
            SAMPLE_BITS'($urandom_range(300, 4095));
      end else if (kind == 6) begin
         foreach (f[i]) f[i] = SAMPLE_BITS'($urandom_range(0, 4095));
      end else if (kind == 7) begin
         case ($urandom_range(0, 2))
            0: f = flat(12'd0);
            1: f = flat(12'd4095);
            default: f = flat(SAMPLE_BITS'($urandom_range(0, 4095)));
         endcase
         f[$urandom_range(0, lfpd_pkg::SENSOR_COUNT - 1)] =
            SAMPLE_BITS'($urandom_range(0, 4095));
      end else if (kind == 8) begin
         f = line_scene();
         f[$urandom_range(5, 6)] = SAMPLE_BITS'($urandom_range(300, 4095));
         if ($urandom_range(0, 1))
            f[$urandom_range(0, 1)] = SAMPLE_BITS'($urandom_range(300, 4095));
         if ($urandom_range(0, 1))
            f[$urandom_range(10, 11)] = SAMPLE_BITS'($urandom_range(300, 4095));
      end else begin
         // samples at or just beside the white and green thresholds
         foreach (f[i]) begin
            case ($urandom_range(0, 4))
               0: f[i] = wl;
               1: f[i] = wl + 1'b1;
               2: f[i] = gl - 1'b1;
               3: f[i] = gl;
               default: f[i] = SAMPLE_BITS'($urandom_range(0, 255));
            endcase
         end
      end
      return f;
   endfunction

   initial begin
      sample_set_t f;
      ledger = new();
      calm = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.sample_0 <= '0;
      req_bus.sample_1 <= '0;
      req_bus.sample_2 <= '0;
      req_bus.sample_3 <= '0;
      req_bus.sample_4 <= '0;
      req_bus.sample_5 <= '0;
      req_bus.sample_6 <= '0;
      req_bus.sample_7 <= '0;
      req_bus.sample_8 <= '0;
      req_bus.sample_9 <= '0;
      req_bus.sample_10 <= '0;
      req_bus.sample_11 <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: guards and line positions in normal tracking
      setup(lfpd_pkg::MODE_NORMAL, 12'd200, 16'h0180, 16'h0040, 12'd250, 12'd140, 12'd250);
      send_frame(flat(12'd0));
      send_frame(flat(12'd4095));
      send_frame(flat(12'd100));
      f = spot(5, 12'd4095, 12'd0); f[6] = 12'd4095; send_frame(f);
      f = spot(5, 12'd600, 12'd60); f[0] = 12'd600; send_frame(f);
      f = spot(6, 12'd600, 12'd60); f[11] = 12'd600; send_frame(f);
      f = spot(2, 12'd600, 12'd60); f[3] = 12'd600; f[8] = 12'd600; send_frame(f);
      send_frame(spot(1, 12'd4095, 12'd0));
      send_frame(spot(10, 12'd4095, 12'd0));
      send_frame(spot(0, 12'd4095, 12'd0));
      send_frame(spot(11, 12'd4095, 12'd0));
      send_frame(flat(12'd200));
      settle();

      // bridge linear at full speed and gains: error beyond the output range
      setup(lfpd_pkg::MODE_BRIDGE_LINEAR, 12'd4095, 16'hFFFF, 16'hFFFF, 12'd0, 12'd4095,
            12'd0);
      send_frame(spot(5, 12'd4095, 12'd0));
      send_frame(spot(6, 12'd4095, 12'd0));
      send_frame(spot(5, 12'd4095, 12'd0));
      send_frame(flat(12'd4095));
      settle();

      // bridge flat just under the speed knee
      setup(lfpd_pkg::MODE_BRIDGE_FLAT, 12'd159, 16'h0100, 16'h0000, 12'd4095, 12'd0,
            12'd4095);
      send_frame(spot(4, 12'd4095, 12'd0));
      send_frame(spot(9, 12'd1, 12'd0));
      send_frame(flat(12'd0));
      settle();

      // spare mode acts as normal tracking; thresholds that never fire
      setup(MODE_SPARE, 12'd160, 16'h0800, 16'h0400, 12'd4095, 12'd0, 12'd4095);
      send_frame(spot(1, 12'd4095, 12'd0));
      send_frame(random_scene());
      settle();

      setup(lfpd_pkg::MODE_NORMAL, 12'd0, lfpd_pkg::GAIN_W'($urandom_range(0, 65535)),
            lfpd_pkg::GAIN_W'($urandom_range(0, 65535)), 12'd250, 12'd140, 12'd250);
      send_frame(spot(3, 12'd2000, 12'd10));
      settle();

      // random phases
      for (int phase = 0; phase < 8; phase++) begin
         calm = (phase % 3 == 1);
         if (phase == 0)
            setup(lfpd_pkg::MODE_NORMAL, 12'd4095, 16'hFFFF, 16'hFFFF, 12'd250, 12'd140,
                  12'd250);
         else if (phase == 1)
            setup(lfpd_pkg::MODE_BRIDGE_LINEAR, 12'd0, 16'h0000, 16'h0000, 12'd0, 12'd0,
                  12'd0);
         else
            random_setup();
         for (int n = 0; n < 200; n++) begin
            send_frame(random_scene());
            if (phase == 3 && n == 100) settle();
         end
         settle();
      end

      calm = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d sample frames over %0d register settings, all four modes and guard cases",
               frames_sent, settings_loaded);
      $display("%0d drive words checked, %0d faults", ledger.checked, ledger.faults);
      if (ledger.faults == 0 && ledger.pending_drives.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
